@@ hdl/jhs_pkg.sv @@
// Shared types and constants for the Jacobi heat stencil core.
// Used by jhs_sweep and jacobi_heat_stencil_core; no dependencies.
package jhs_pkg;

  // Default interior size per side and stored value width.
  localparam int unsigned JHS_MAX_INTERIOR = 62;
  localparam int unsigned JHS_VALUE_BITS   = 32;

  // Fixed field widths of the ports.
  localparam int unsigned JHS_COORD_W = 6;
  localparam int unsigned JHS_COUNT_W = 16;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } jhs_op_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [1:0] CFG_ITER_LIM  = 2'd1;
  localparam logic [1:0] CFG_STOP_THR  = 2'd2;

  // Status handed back by the sweep engine at the end of a run.
  typedef struct packed {
    logic                   done;
    logic [JHS_COUNT_W-1:0] sweeps;
    logic                   converged;
    logic                   bank;
  } jhs_status_t;

endpackage

@@ hdl/jhs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module jhs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/jhs_sweep.sv @@
// Sweep engine: walks the interior cell by cell, reading five cells through
// one RAM read port and updating one accumulator. Depends on jhs_pkg.
module jhs_sweep
  import jhs_pkg::*;
#(
  parameter int unsigned MAX_INTERIOR = JHS_MAX_INTERIOR,
  parameter int unsigned VALUE_BITS   = JHS_VALUE_BITS,
  parameter int unsigned CB           = $clog2(MAX_INTERIOR + 2)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [CB-1:0]          n,
  input  logic [JHS_COUNT_W-1:0] limit,
  input  logic [31:0]            threshold,
  input  logic                   bank_in,
  output logic [2*CB-1:0]        rd_addr,
  output logic                   rd_bank,
  input  logic [VALUE_BITS-1:0]  rd_data,
  output logic                   wr_en,
  output logic                   wr_bank,
  output logic [2*CB-1:0]        wr_addr,
  output logic [VALUE_BITS-1:0]  wr_data,
  output jhs_status_t            status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CELL,
    S_END
  } state_t;

  // Step of one cell: five reads issued on steps zero to four, result on five.
  localparam logic [2:0] STEP_LAST = 3'd5;

  state_t                  state_r, state_nxt;
  logic [CB-1:0]           row_r, row_nxt;
  logic [CB-1:0]           col_r, col_nxt;
  logic [2:0]              step_r, step_nxt;
  logic [VALUE_BITS+1:0]   acc_r, acc_nxt;
  logic [VALUE_BITS-1:0]   maxd_r, maxd_nxt;
  logic [JHS_COUNT_W-1:0]  sweeps_r, sweeps_nxt;
  logic                    bank_r, bank_nxt;
  jhs_status_t             status_r, status_nxt;

  logic [VALUE_BITS-1:0]   new_val;
  logic [VALUE_BITS-1:0]   diff;
  logic [CB-1:0]           rd_row, rd_col;
  logic                    stop_thr;
  logic [31:0]             thr_v;

  // Neighbour address for the current step.
  always_comb begin
    rd_row = row_r;
    rd_col = col_r;
    unique case (step_r)
      3'd0:    rd_row = row_r - 1'b1;
      3'd1:    rd_col = col_r - 1'b1;
      3'd2:    rd_row = row_r + 1'b1;
      3'd3:    rd_col = col_r + 1'b1;
      default: begin
        rd_row = row_r;
        rd_col = col_r;
      end
    endcase
  end

  assign rd_addr = {rd_row, rd_col};
  assign rd_bank = bank_r;

  // Truncated mean and absolute change against the centre cell.
  assign new_val = acc_r[VALUE_BITS+1:2];
  assign diff    = (new_val > rd_data) ? (new_val - rd_data) : (rd_data - new_val);

  assign wr_en   = (state_r == S_CELL) && (step_r == STEP_LAST);
  assign wr_bank = ~bank_r;
  assign wr_addr = {row_r, col_r};
  assign wr_data = new_val;

  assign thr_v    = threshold;
  assign stop_thr = (thr_v != 32'd0) &&
                    ({{(VALUE_BITS > 32 ? VALUE_BITS - 32 : 0){1'b0}}, thr_v}
                     > {{(VALUE_BITS < 32 ? 32 - VALUE_BITS : 0){1'b0}}, maxd_r});

  // Sequencer next state.
  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    step_nxt   = step_r;
    acc_nxt    = acc_r;
    maxd_nxt   = maxd_r;
    sweeps_nxt = sweeps_r;
    bank_nxt   = bank_r;
    status_nxt = status_r;
    status_nxt.done = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          bank_nxt   = bank_in;
          sweeps_nxt = '0;
          maxd_nxt   = '0;
          row_nxt    = CB'(1);
          col_nxt    = CB'(1);
          step_nxt   = '0;
          if (limit == '0) begin
            status_nxt = '{done: 1'b1, sweeps: '0, converged: 1'b0, bank: bank_in};
          end else begin
            state_nxt = S_CELL;
          end
        end
      end
      S_CELL: begin
        // Accumulate the four neighbours as they come back from the RAM.
        if (step_r == 3'd1) begin
          acc_nxt = {2'b00, rd_data};
        end else if (step_r >= 3'd2 && step_r <= 3'd4) begin
          acc_nxt = acc_r + {2'b00, rd_data};
        end
        if (step_r == STEP_LAST) begin
          step_nxt = '0;
          if (diff > maxd_r) begin
            maxd_nxt = diff;
          end
          if (col_r == n) begin
            col_nxt = CB'(1);
            if (row_r == n) begin
              state_nxt = S_END;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_END: begin
        bank_nxt   = ~bank_r;
        sweeps_nxt = sweeps_r + 1'b1;
        maxd_nxt   = '0;
        row_nxt    = CB'(1);
        col_nxt    = CB'(1);
        if (stop_thr || (sweeps_nxt == limit)) begin
          state_nxt  = S_IDLE;
          status_nxt = '{done: 1'b1, sweeps: sweeps_nxt, converged: stop_thr,
                         bank: ~bank_r};
        end else begin
          state_nxt = S_CELL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= '0;
      step_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      step_r   <= step_nxt;
    end
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    acc_r    <= acc_nxt;
    maxd_r   <= maxd_nxt;
    sweeps_r <= sweeps_nxt;
    bank_r   <= bank_nxt;
  end

  assign status = status_r;

`ifndef SYNTHESIS
  // The cell walk stays inside the interior.
  a_row_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CELL) |-> (row_r >= CB'(1) && row_r <= n && col_r >= CB'(1) && col_r <= n))
    else $error("sweep left the interior");
  // A finished run never reports more sweeps than the limit.
  a_sweeps_limit: assert property (@(posedge clk) disable iff (!rst_n)
    status_r.done |-> (status_r.sweeps <= limit))
    else $error("sweep count beyond limit");
  // Completion is a single-cycle pulse.
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    status_r.done |=> !status_r.done)
    else $error("done held for two cycles");
`endif

endmodule

@@ hdl/jacobi_heat_stencil_core.sv @@
// Jacobi heat stencil core: top level. Depends on jhs_pkg, jhs_ram, jhs_sweep.
// Write and unused words are answered directly from the idle state; read words pass through a
// read state, and a run word holds the core until the sweep engine hands back the status. Each cell
// needs five reads through the one RAM read port of the sweep engine and a further
// step to write the mean; the banks swap at the end of every sweep.
module jacobi_heat_stencil_core
  import jhs_pkg::*;
#(
  parameter int unsigned MAX_INTERIOR = JHS_MAX_INTERIOR
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_operation,
  input  logic [JHS_COORD_W-1:0] in_row,
  input  logic [JHS_COORD_W-1:0] in_col,
  input  logic [31:0]            in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            out_temperature,
  output logic [JHS_COUNT_W-1:0] out_sweeps_done,
  output logic                   out_converged,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int unsigned CB    = $clog2(MAX_INTERIOR + 2);
  localparam int unsigned CW    = ((CB > JHS_COORD_W) ? CB : JHS_COORD_W) + 1;
  localparam int unsigned VB    = JHS_VALUE_BITS;
  localparam int unsigned DEPTH = 1 << (2 * CB);

  typedef enum logic [1:0] {
    T_IDLE,
    T_READ,
    T_RUN
  } state_t;

  state_t                  state_r;
  logic [JHS_COORD_W-1:0]  grid_size_r;
  logic [JHS_COUNT_W-1:0]  iter_lim_r;
  logic [31:0]             stop_thr_r;
  logic                    bank_r;
  logic [JHS_COUNT_W-1:0]  last_sweeps_r;
  logic                    last_conv_r;
  logic                    rd_inside_r;
  logic                    rd_sel_r;
  logic                    out_valid_r;
  logic [31:0]             out_temperature_r;
  logic [JHS_COUNT_W-1:0]  out_sweeps_done_r;
  logic                    out_converged_r;

  logic [CB-1:0]           n_eff;
  logic [CW-1:0]           lim;
  logic                    in_grid;
  logic                    accept;
  jhs_op_t                 op;
  logic [2*CB-1:0]         host_addr;

  logic [2*CB-1:0]         sw_rd_addr, sw_wr_addr;
  logic                    sw_rd_bank, sw_wr_en, sw_wr_bank;
  logic [VB-1:0]           sw_wr_data;
  logic [VB-1:0]           rdata0, rdata1, rd_data;
  jhs_status_t             sw_status;

  logic [2*CB-1:0]         raddr, waddr;
  logic [VB-1:0]           wdata;
  logic                    we0, we1;

  // Effective interior size, saturated to one through the maximum.
  always_comb begin
    priority if (grid_size_r == '0) begin
      n_eff = CB'(1);
    end else if (CW'(grid_size_r) > CW'(MAX_INTERIOR)) begin
      n_eff = CB'(MAX_INTERIOR);
    end else begin
      n_eff = CB'(grid_size_r);
    end
  end

  assign lim       = CW'(n_eff) + CW'(1);
  assign in_grid   = (CW'(in_row) <= lim) && (CW'(in_col) <= lim);
  assign op        = jhs_op_t'(in_operation);
  assign in_ready  = (state_r == T_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign host_addr = {CB'(in_row), CB'(in_col)};

  // RAM port selection between host words and the sweep engine.
  assign raddr = (state_r == T_RUN) ? sw_rd_addr : host_addr;
  assign waddr = (state_r == T_RUN) ? sw_wr_addr : host_addr;
  assign wdata = (state_r == T_RUN) ? sw_wr_data : VB'(in_value);
  always_comb begin
    if (state_r == T_RUN) begin
      we0 = sw_wr_en && !sw_wr_bank;
      we1 = sw_wr_en && sw_wr_bank;
    end else begin
      we0 = accept && (op == OP_WRITE) && in_grid;
      we1 = we0;
    end
  end

  jhs_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_bank0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata0)
  );

  jhs_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_bank1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata1)
  );

  assign rd_data = rd_sel_r ? rdata1 : rdata0;

  jhs_sweep #(.MAX_INTERIOR(MAX_INTERIOR), .VALUE_BITS(VB), .CB(CB)) u_sweep (
    .clk(clk),
    .rst_n(rst_n),
    .start(accept && (op == OP_RUN)),
    .n(n_eff),
    .limit(iter_lim_r),
    .threshold(stop_thr_r),
    .bank_in(bank_r),
    .rd_addr(sw_rd_addr),
    .rd_bank(sw_rd_bank),
    .rd_data(rd_data),
    .wr_en(sw_wr_en),
    .wr_bank(sw_wr_bank),
    .wr_addr(sw_wr_addr),
    .wr_data(sw_wr_data),
    .status(sw_status)
  );

  // Item sequencing, configuration and the output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= T_IDLE;
      grid_size_r   <= JHS_COORD_W'(62);
      iter_lim_r    <= JHS_COUNT_W'(1);
      stop_thr_r    <= '0;
      bank_r        <= 1'b0;
      last_sweeps_r <= '0;
      last_conv_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_SIZE: grid_size_r <= cfg_data[JHS_COORD_W-1:0];
          CFG_ITER_LIM:  iter_lim_r  <= cfg_data[JHS_COUNT_W-1:0];
          CFG_STOP_THR:  stop_thr_r  <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        T_IDLE: begin
          if (accept) begin
            unique case (op)
              OP_READ: state_r <= T_READ;
              OP_RUN:  state_r <= T_RUN;
              default: begin
                out_valid_r       <= 1'b1;
                out_temperature_r <= '0;
                out_sweeps_done_r <= last_sweeps_r;
                out_converged_r   <= last_conv_r;
              end
            endcase
          end
        end
        T_READ: begin
          state_r           <= T_IDLE;
          out_valid_r       <= 1'b1;
          out_temperature_r <= rd_inside_r ? 32'(rd_data) : 32'd0;
          out_sweeps_done_r <= last_sweeps_r;
          out_converged_r   <= last_conv_r;
        end
        T_RUN: begin
          if (sw_status.done) begin
            state_r           <= T_IDLE;
            bank_r            <= sw_status.bank;
            last_sweeps_r     <= sw_status.sweeps;
            last_conv_r       <= sw_status.converged;
            out_valid_r       <= 1'b1;
            out_temperature_r <= '0;
            out_sweeps_done_r <= sw_status.sweeps;
            out_converged_r   <= sw_status.converged;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
    rd_inside_r <= in_grid;
    rd_sel_r    <= (state_r == T_RUN) ? sw_rd_bank : bank_r;
  end

  assign out_valid       = out_valid_r;
  assign out_temperature = out_temperature_r;
  assign out_sweeps_done = out_sweeps_done_r;
  assign out_converged   = out_converged_r;

`ifndef SYNTHESIS
  // No word is taken while a previous one is still in flight.
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != T_IDLE) |-> !in_ready)
    else $error("ready while busy");
  // The sweep engine only reports completion during a run.
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    sw_status.done |-> (state_r == T_RUN))
    else $error("sweep completion outside a run");
  // The sweep engine writes the RAM only during a run.
  a_sweep_write: assert property (@(posedge clk) disable iff (!rst_n)
    sw_wr_en |-> (state_r == T_RUN))
    else $error("sweep write outside a run");
  // The read state always yields a valid result on the following cycle.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_READ) |=> out_valid_r)
    else $error("read result missing");
`endif

endmodule
